// ===== rtl/erf_pkg.sv =====
// Shared types and constants for the relocation table fixup block.
`timescale 1ns / 1ps

package erf_pkg;

  localparam int unsigned AddrW    = 24;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);

  // Pointer step for a delta of one.
  localparam logic [DataW-1:0] LongStep = DataW'(254);

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_ERROR  = 2'd3
  } erf_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_ODD_DELTA  = 2'd1,
    ERR_IMAGE_END  = 2'd2,
    ERR_FILE_END   = 2'd3
  } erf_err_e;

  typedef enum logic [1:0] {
    REG_TEXT_BASE     = 2'd0,
    REG_IMAGE_END     = 2'd1,
    REG_FILE_END      = 2'd2,
    REG_VALIDATE_ONLY = 2'd3
  } erf_reg_e;

  typedef struct packed {
    logic             mode;
    logic             start_req;
    logic [DataW-1:0] data;
  } erf_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] value;
    logic [1:0]       error_code;
  } erf_out_t;

  typedef struct packed {
    logic [AddrW-1:0] text_base;
    logic [AddrW-1:0] image_end;
    logic [AddrW-1:0] file_end;
    logic             validate_only;
  } erf_cfg_t;

  // One decoded action passed from the decoder to the output stage.
  typedef struct packed {
    erf_kind_e        kind;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
    erf_err_e         error_code;
  } erf_cmd_t;

endpackage

// ===== rtl/executable_relocation_fixup_top.sv =====
// Relocation table fixup: configuration registers, decoder, queue and output stage.
// An item's action is written into the queue, then loaded into the result register behind out_valid_o.
// Throughput: one item per cycle unless stalled; a run byte needs one pointer add and compares.
// The two-entry queue lets input transfers continue while the output stalls.
// Reset clears the configuration, the decoder state, the queue and the output valid.
`timescale 1ns / 1ps

module executable_relocation_fixup_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [23:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  input  erf_pkg::erf_in_t in_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output erf_pkg::erf_out_t out_o,
  input  logic             out_stall_i
);
  import erf_pkg::*;

  erf_cfg_t cfg_q;
  logic     push;
  erf_cmd_t push_cmd;
  logic     full;
  logic     pop;
  erf_cmd_t pop_cmd;
  logic     empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEXT_BASE:     cfg_q.text_base     <= cfg_wdata_i;
        REG_IMAGE_END:     cfg_q.image_end     <= cfg_wdata_i;
        REG_FILE_END:      cfg_q.file_end      <= cfg_wdata_i;
        REG_VALIDATE_ONLY: cfg_q.validate_only <= cfg_wdata_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  erf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  erf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  erf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== rtl/erf_front.sv =====
// Table decoder: accepts items, tracks the patch pointer and classifies actions.
`timescale 1ns / 1ps

module erf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  erf_pkg::erf_cfg_t cfg_i,
  input  logic              in_valid_i,
  input  erf_pkg::erf_in_t  in_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output erf_pkg::erf_cmd_t push_cmd_o
);
  import erf_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_RUN  = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [DataW-1:0] ptr_q, ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [AddrW-1:0] acc_q, acc_d;

  logic             accept;
  logic [7:0]       tbyte;
  logic             in_head;
  logic [DataW-1:0] first;
  logic [DataW-1:0] delta;
  logic [DataW-1:0] step;
  logic [DataW-1:0] base;
  logic [DataW:0]   sum;
  logic [DataW-1:0] ptr_new;
  logic             past_image;
  logic             past_file;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign tbyte      = in_i.data[7:0];
  assign in_head    = (phase_q == PH_HEAD);
  assign first      = {acc_q, tbyte};

  // Shared pointer adder: the head adds the first offset to the text base,
  // the run phase adds the delta to the running pointer. Sums saturate.
  assign delta      = in_head ? first : {{(DataW-8){1'b0}}, tbyte};
  assign step       = (delta == DataW'(1)) ? LongStep : delta;
  assign base       = in_head ? {{(DataW-AddrW){1'b0}}, cfg_i.text_base} : ptr_q;
  assign sum        = {1'b0, base} + {1'b0, step};
  assign ptr_new    = sum[DataW] ? '1 : sum[DataW-1:0];
  assign past_image = ptr_new >= {{(DataW-AddrW){1'b0}}, cfg_i.image_end};
  assign past_file  = ptr_q >= {{(DataW-AddrW){1'b0}}, cfg_i.file_end};

  always_comb begin
    logic take;
    take       = 1'b0;
    phase_d    = phase_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: KIND_FINISH, address: '0, data: '0, error_code: ERR_NONE};

    if (accept) begin
      if (in_i.mode) begin
        if (phase_q == PH_WAIT) begin
          phase_d            = PH_RUN;
          push_o             = 1'b1;
          push_cmd_o.kind    = KIND_WRITE;
          push_cmd_o.address = ptr_q[AddrW-1:0];
          push_cmd_o.data    = in_i.data;
        end
      end else if (in_i.start_req) begin
        acc_d   = {{(AddrW-8){1'b0}}, tbyte};
        cnt_d   = 2'd1;
        ptr_d   = '0;
        phase_d = PH_HEAD;
      end else if (in_head) begin
        if (cnt_q != 2'd3) begin
          acc_d = {acc_q[AddrW-9:0], tbyte};
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = 2'd0;
          acc_d = '0;
          ptr_d = {{(DataW-AddrW){1'b0}}, cfg_i.text_base};
          if (first == '0) begin
            phase_d = PH_DONE;
            push_o  = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
      end else if (phase_q == PH_RUN) begin
        if (past_file) begin
          phase_d               = PH_DONE;
          push_o                = 1'b1;
          push_cmd_o.kind       = KIND_ERROR;
          push_cmd_o.error_code = ERR_FILE_END;
        end else if (tbyte == 8'd0) begin
          phase_d = PH_DONE;
          push_o  = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
    end

    if (take) begin
      ptr_d = ptr_new;
      if (delta == DataW'(1)) begin
        phase_d = PH_RUN;
      end else if (delta[0]) begin
        phase_d               = PH_DONE;
        push_o                = 1'b1;
        push_cmd_o.kind       = KIND_ERROR;
        push_cmd_o.error_code = ERR_ODD_DELTA;
      end else if (past_image) begin
        phase_d               = PH_DONE;
        push_o                = 1'b1;
        push_cmd_o.kind       = KIND_ERROR;
        push_cmd_o.error_code = ERR_IMAGE_END;
      end else if (cfg_i.validate_only) begin
        phase_d = PH_RUN;
      end else begin
        phase_d            = PH_WAIT;
        push_o             = 1'b1;
        push_cmd_o.kind    = KIND_READ;
        push_cmd_o.address = ptr_new[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
    end
  end

  // The header byte count is only live while the header is being assembled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (phase_q == PH_HEAD))
    else $error("header count set outside the header phase");

  // Nothing has moved the pointer before the first start byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (ptr_q == '0))
    else $error("pointer moved before any table start");

endmodule

// ===== rtl/erf_fifo.sv =====
// Short command queue between the table decoder and the output stage.
`timescale 1ns / 1ps

module erf_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  erf_pkg::erf_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output erf_pkg::erf_cmd_t cmd_o,
  output logic              empty_o
);
  import erf_pkg::*;

  erf_cmd_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue fill count beyond its depth");

  // A push without a pop grows the fill count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count lost a push");

endmodule

// ===== rtl/erf_back.sv =====
// Output stage: relocates fetched longwords and holds the result register.
`timescale 1ns / 1ps

module erf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  erf_pkg::erf_cfg_t cfg_i,
  input  logic              empty_i,
  input  erf_pkg::erf_cmd_t cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  output erf_pkg::erf_out_t out_o,
  input  logic              out_stall_i
);
  import erf_pkg::*;

  logic     valid_q;
  erf_out_t res_q, res_d;

  // A queued command loads if the register is empty or its result leaves this cycle.
  assign pop_o       = ~empty_i & (~valid_q | ~out_stall_i);
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    res_d.kind       = cmd_i.kind;
    res_d.address    = cmd_i.address;
    res_d.error_code = cmd_i.error_code;
    res_d.value      = '0;
    if (cmd_i.kind == KIND_WRITE) begin
      res_d.value = cmd_i.data + {{(DataW-AddrW){1'b0}}, cfg_i.text_base};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Only write results carry a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (res_q.kind != KIND_WRITE)) |-> (res_q.value == '0))
    else $error("nonzero value on a result other than a write");

endmodule
